[rtl/i2cm_pkg.sv]
// shared constants for the i2c master bit engine: op codes, status codes,
// phase codes and beat layout widths. no dependencies
`default_nettype none

package i2cm_pkg;

  // op codes carried in each input beat
  localparam logic [2:0] OP_TICK  = 3'd0;
  localparam logic [2:0] OP_START = 3'd1;
  localparam logic [2:0] OP_STOP  = 3'd2;
  localparam logic [2:0] OP_WRITE = 3'd3;
  localparam logic [2:0] OP_RDACK = 3'd4;
  localparam logic [2:0] OP_RDNAK = 3'd5;

  // status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_BUSY = 2'd1;
  localparam logic [1:0] ST_ERR  = 2'd2;
  localparam logic [1:0] ST_NACK = 2'd3;

  // phase codes
  localparam logic [4:0] PH_IDLE  = 5'd0;
  localparam logic [4:0] PH_ST_A  = 5'd1;
  localparam logic [4:0] PH_ST_B  = 5'd2;
  localparam logic [4:0] PH_ST_C  = 5'd3;
  localparam logic [4:0] PH_ST_D  = 5'd4;
  localparam logic [4:0] PH_SP_A  = 5'd5;
  localparam logic [4:0] PH_SP_B  = 5'd6;
  localparam logic [4:0] PH_SP_C  = 5'd7;
  localparam logic [4:0] PH_WR_D  = 5'd8;
  localparam logic [4:0] PH_WR_H  = 5'd9;
  localparam logic [4:0] PH_WR_L  = 5'd10;
  localparam logic [4:0] PH_WR_AR = 5'd11;
  localparam logic [4:0] PH_WR_AH = 5'd12;
  localparam logic [4:0] PH_RD_H  = 5'd13;
  localparam logic [4:0] PH_RD_L  = 5'd14;
  localparam logic [4:0] PH_RD_K  = 5'd15;
  localparam logic [4:0] PH_RD_KH = 5'd16;
  localparam logic [4:0] PH_RD_KL = 5'd17;

  localparam int unsigned TICK_W = 16;
  localparam int unsigned IN_W   = 16;
  localparam int unsigned OUT_W  = 16;

  // one result beat
  typedef struct packed {
    logic       cmd_rejected;
    logic [7:0] rx_byte;
    logic [1:0] status;
    logic       done_res;
    logic       busy_res;
    logic       sda_drive;
    logic       scl_drive;
  } result_t;

endpackage

`default_nettype wire

[rtl/i2c_master_bit_engine.sv]
// i2c master bit engine top level: one tick per input beat, one result per beat
// depends on i2cm_pkg
// a result beat is registered and appears in the cycle after its input beat is accepted
// throughput: one beat per cycle while each result is taken; the output register frees up as it is taken
// the phase state advances in the same cycle a beat is accepted
// reset: phase idle, both lines released, status and rx byte zero,
// phase_ticks 1, no result pending
`default_nettype none

module i2c_master_bit_engine (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [i2cm_pkg::TICK_W-1:0]   cfg_wdata,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // op [2:0], tx_byte [10:3], sda_in [11], zero [15:12]
  input  wire logic [i2cm_pkg::IN_W-1:0]     s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // scl_drive [0], sda_drive [1], busy_res [2], done_res [3], status [5:4],
  // rx_byte [13:6], cmd_rejected [14], zero [15]
  output logic [i2cm_pkg::OUT_W-1:0]         m_axis_tdata
);

  logic [15:0] phase_ticks;
  logic [4:0]  phase, phase_next;
  logic [2:0]  active_cmd, active_cmd_next;
  logic [2:0]  bit_count, bit_count_next;
  logic [7:0]  shift_reg, shift_reg_next;
  logic [15:0] wait_count, wait_count_next;
  logic        scl_level, scl_level_next;
  logic        sda_level, sda_level_next;
  logic [1:0]  last_status, last_status_next;
  logic [7:0]  rx_hold, rx_hold_next;
  logic        done, rejected;
  logic        do_enter;
  logic [4:0]  enter_ph;
  logic [15:0] wc_dec;
  logic [15:0] load_ticks;
  logic [2:0]  op;
  logic [7:0]  tx;
  logic        sda;
  logic        is_cmd;
  logic        accept;
  i2cm_pkg::result_t res;
  i2cm_pkg::result_t res_q;

  assign op  = s_axis_tdata[2:0];
  assign tx  = s_axis_tdata[10:3];
  assign sda = s_axis_tdata[11];
  assign is_cmd = (op >= i2cm_pkg::OP_START) && (op <= i2cm_pkg::OP_RDNAK);

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign load_ticks    = (phase_ticks == 16'd0) ? 16'd1 : phase_ticks;
  assign wc_dec        = (wait_count != 16'd0) ? wait_count - 16'd1 : 16'd0;

  always_comb begin
    phase_next       = phase;
    active_cmd_next  = active_cmd;
    bit_count_next   = bit_count;
    shift_reg_next   = shift_reg;
    wait_count_next  = wait_count;
    scl_level_next   = scl_level;
    sda_level_next   = sda_level;
    last_status_next = last_status;
    rx_hold_next     = rx_hold;
    done             = 1'b0;
    rejected         = 1'b0;
    do_enter         = 1'b0;
    enter_ph         = i2cm_pkg::PH_IDLE;

    if (phase == i2cm_pkg::PH_IDLE) begin
      if (is_cmd) begin
        active_cmd_next = op;
        bit_count_next  = 3'd0;
        do_enter        = 1'b1;
        priority if (op == i2cm_pkg::OP_START) begin
          enter_ph = i2cm_pkg::PH_ST_A;
        end else if (op == i2cm_pkg::OP_STOP) begin
          enter_ph = i2cm_pkg::PH_SP_A;
        end else if (op == i2cm_pkg::OP_WRITE) begin
          shift_reg_next = tx;
          enter_ph       = i2cm_pkg::PH_WR_D;
        end else begin
          shift_reg_next = 8'd0;
          enter_ph       = i2cm_pkg::PH_RD_H;
        end
      end
    end else begin
      rejected        = is_cmd;
      wait_count_next = wc_dec;
      if (wc_dec == 16'd0) begin
        do_enter = 1'b1;
        unique case (phase)
          i2cm_pkg::PH_ST_A: enter_ph = i2cm_pkg::PH_ST_B;
          i2cm_pkg::PH_ST_B: begin
            if (!sda) begin
              do_enter         = 1'b0;
              done             = 1'b1;
              last_status_next = i2cm_pkg::ST_BUSY;
            end else begin
              enter_ph = i2cm_pkg::PH_ST_C;
            end
          end
          i2cm_pkg::PH_ST_C: enter_ph = i2cm_pkg::PH_ST_D;
          i2cm_pkg::PH_ST_D: begin
            do_enter         = 1'b0;
            done             = 1'b1;
            last_status_next = sda ? i2cm_pkg::ST_ERR : i2cm_pkg::ST_OK;
          end
          i2cm_pkg::PH_SP_A: enter_ph = i2cm_pkg::PH_SP_B;
          i2cm_pkg::PH_SP_B: enter_ph = i2cm_pkg::PH_SP_C;
          i2cm_pkg::PH_WR_D: enter_ph = i2cm_pkg::PH_WR_H;
          i2cm_pkg::PH_WR_H: enter_ph = i2cm_pkg::PH_WR_L;
          i2cm_pkg::PH_WR_L: begin
            if (bit_count == 3'd7) begin
              enter_ph = i2cm_pkg::PH_WR_AR;
            end else begin
              bit_count_next = bit_count + 3'd1;
              enter_ph       = i2cm_pkg::PH_WR_D;
            end
          end
          i2cm_pkg::PH_WR_AR: enter_ph = i2cm_pkg::PH_WR_AH;
          i2cm_pkg::PH_WR_AH: begin
            do_enter         = 1'b0;
            done             = 1'b1;
            scl_level_next   = 1'b0;
            last_status_next = sda ? i2cm_pkg::ST_NACK : i2cm_pkg::ST_OK;
          end
          i2cm_pkg::PH_RD_H: begin
            shift_reg_next = {shift_reg[6:0], sda};
            enter_ph       = i2cm_pkg::PH_RD_L;
          end
          i2cm_pkg::PH_RD_L: begin
            if (bit_count == 3'd7) begin
              rx_hold_next = shift_reg;
              enter_ph     = i2cm_pkg::PH_RD_K;
            end else begin
              bit_count_next = bit_count + 3'd1;
              enter_ph       = i2cm_pkg::PH_RD_H;
            end
          end
          i2cm_pkg::PH_RD_K:  enter_ph = i2cm_pkg::PH_RD_KH;
          i2cm_pkg::PH_RD_KH: enter_ph = i2cm_pkg::PH_RD_KL;
          default: begin
            // end of stop or read sequence, and any stray code
            do_enter         = 1'b0;
            done             = 1'b1;
            last_status_next = i2cm_pkg::ST_OK;
          end
        endcase
        if (done) begin
          phase_next      = i2cm_pkg::PH_IDLE;
          wait_count_next = 16'd0;
        end
      end
    end

    // pin levels set on entry to a phase
    if (do_enter) begin
      phase_next      = enter_ph;
      wait_count_next = load_ticks;
      unique case (enter_ph)
        i2cm_pkg::PH_ST_A:  sda_level_next = 1'b1;
        i2cm_pkg::PH_ST_B:  scl_level_next = 1'b1;
        i2cm_pkg::PH_ST_C:  sda_level_next = 1'b0;
        i2cm_pkg::PH_ST_D:  scl_level_next = 1'b0;
        i2cm_pkg::PH_SP_A:  sda_level_next = 1'b0;
        i2cm_pkg::PH_SP_B:  scl_level_next = 1'b1;
        i2cm_pkg::PH_SP_C:  sda_level_next = 1'b1;
        i2cm_pkg::PH_WR_D: begin
          scl_level_next = 1'b0;
          sda_level_next = shift_reg_next[7];
          shift_reg_next = {shift_reg_next[6:0], 1'b0};
        end
        i2cm_pkg::PH_WR_H:  scl_level_next = 1'b1;
        i2cm_pkg::PH_WR_L:  scl_level_next = 1'b0;
        i2cm_pkg::PH_WR_AR: sda_level_next = 1'b1;
        i2cm_pkg::PH_WR_AH: scl_level_next = 1'b1;
        i2cm_pkg::PH_RD_H: begin
          sda_level_next = 1'b1;
          scl_level_next = 1'b1;
        end
        i2cm_pkg::PH_RD_L:  scl_level_next = 1'b0;
        i2cm_pkg::PH_RD_K:  sda_level_next = (active_cmd_next == i2cm_pkg::OP_RDNAK);
        i2cm_pkg::PH_RD_KH: scl_level_next = 1'b1;
        i2cm_pkg::PH_RD_KL: scl_level_next = 1'b0;
        default: ;
      endcase
    end

    res.scl_drive    = scl_level_next;
    res.sda_drive    = sda_level_next;
    res.busy_res     = (phase_next != i2cm_pkg::PH_IDLE);
    res.done_res     = done;
    res.status       = last_status_next;
    res.rx_byte      = rx_hold_next;
    res.cmd_rejected = rejected;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_ticks <= 16'd1;
    end else if (cfg_we) begin
      phase_ticks <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= i2cm_pkg::PH_IDLE;
      active_cmd  <= 3'd0;
      bit_count   <= 3'd0;
      shift_reg   <= 8'd0;
      wait_count  <= 16'd0;
      scl_level   <= 1'b1;
      sda_level   <= 1'b1;
      last_status <= i2cm_pkg::ST_OK;
      rx_hold     <= 8'd0;
    end else if (accept) begin
      phase       <= phase_next;
      active_cmd  <= active_cmd_next;
      bit_count   <= bit_count_next;
      shift_reg   <= shift_reg_next;
      wait_count  <= wait_count_next;
      scl_level   <= scl_level_next;
      sda_level   <= sda_level_next;
      last_status <= last_status_next;
      rx_hold     <= rx_hold_next;
    end
  end

  // output register, refilled whenever a beat is accepted
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (accept) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_q <= res;
    end
  end

  assign m_axis_tdata = {1'b0, res_q};

endmodule

`default_nettype wire

[dv/tb_i2c_master_bit_engine.sv]
// self-checking bench for the i2c master bit engine: directed table then random ticks,
// every result beat compared with a cycle model of the phase sequencer
// depends on i2cm_pkg and the i2c_master_bit_engine rtl
`timescale 1ns / 100ps

module tb_i2c_master_bit_engine;

  localparam logic [2:0] OP_UNDEF6 = 3'd6;
  localparam logic [2:0] OP_UNDEF7 = 3'd7;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned LONG_HOLD = 300;
  localparam int unsigned ITEMS_PER_SETTING = 220;
  localparam int unsigned LONG_PHASE_BEATS = 50;

  // typed result beats: {cmd_rejected, rx_byte, status, done, busy, sda, scl}
  localparam i2cm_pkg::result_t IDLE_BEAT =
    '{1'b0, 8'h00, i2cm_pkg::ST_OK, 1'b0, 1'b0, 1'b1, 1'b1};
  localparam i2cm_pkg::result_t BUS_BUSY_BEAT =
    '{1'b0, 8'h00, i2cm_pkg::ST_BUSY, 1'b1, 1'b0, 1'b1, 1'b1};
  localparam i2cm_pkg::result_t BUS_ERR_BEAT =
    '{1'b0, 8'h00, i2cm_pkg::ST_ERR, 1'b1, 1'b0, 1'b0, 1'b0};
  localparam i2cm_pkg::result_t START_OK_BEAT =
    '{1'b0, 8'h00, i2cm_pkg::ST_OK, 1'b1, 1'b0, 1'b0, 1'b0};
  localparam i2cm_pkg::result_t WR_NACK_BEAT =
    '{1'b0, 8'h00, i2cm_pkg::ST_NACK, 1'b1, 1'b0, 1'b1, 1'b0};
  localparam i2cm_pkg::result_t RD_ACK_BEAT =
    '{1'b0, 8'hFF, i2cm_pkg::ST_OK, 1'b1, 1'b0, 1'b0, 1'b0};
  localparam i2cm_pkg::result_t RD_NACK_BEAT =
    '{1'b0, 8'h00, i2cm_pkg::ST_OK, 1'b1, 1'b0, 1'b1, 1'b0};
  localparam i2cm_pkg::result_t STOP_REJ_BEAT =
    '{1'b1, 8'h00, i2cm_pkg::ST_OK, 1'b1, 1'b0, 1'b1, 1'b1};
  localparam i2cm_pkg::result_t NO_BEAT = '0;

  typedef struct packed {
    logic [2:0]        op;
    logic [7:0]        tx;
    logic              sda;
    logic [7:0]        reps;
    logic              typed;
    i2cm_pkg::result_t beat;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;

  bit          idle_on = 1'b1;
  bit          hold_req = 1'b0;
  int unsigned mismatches = 0;
  int unsigned beats_seen = 0;
  i2cm_pkg::result_t expected_beats [$];

  // engine model state
  logic [15:0] cfg_ticks = 16'd1;
  logic [4:0]  eng_phase = i2cm_pkg::PH_IDLE;
  logic [2:0]  eng_cmd = i2cm_pkg::OP_TICK;
  logic [2:0]  eng_bit = '0;
  logic [7:0]  eng_shift = '0;
  logic [15:0] eng_wait = '0;
  logic        eng_scl = 1'b1;
  logic        eng_sda = 1'b1;
  logic [1:0]  eng_status = i2cm_pkg::ST_OK;
  logic [7:0]  eng_rx = '0;

  int unsigned tick_plan [7] = '{0, 2, 1, 3, 7, 1, 4};

  // walks every command at phase_ticks 1, straight after reset
  dir_row_t dir_rows [0:28] = '{
    '{i2cm_pkg::OP_TICK,  8'h00, 1'b1, 8'd1,  1'b1, IDLE_BEAT},
    '{OP_UNDEF6,          8'h00, 1'b0, 8'd1,  1'b1, IDLE_BEAT},
    '{OP_UNDEF7,          8'hFF, 1'b1, 8'd1,  1'b1, IDLE_BEAT},
    '{i2cm_pkg::OP_START, 8'h00, 1'b1, 8'd1,  1'b0, NO_BEAT},
    '{i2cm_pkg::OP_STOP,  8'h00, 1'b0, 8'd1,  1'b0, NO_BEAT},
    '{i2cm_pkg::OP_TICK,  8'h00, 1'b0, 8'd1,  1'b1, BUS_BUSY_BEAT},
    '{i2cm_pkg::OP_START, 8'h00, 1'b1, 8'd1,  1'b0, NO_BEAT},
    '{i2cm_pkg::OP_TICK,  8'h00, 1'b1, 8'd3,  1'b0, NO_BEAT},
    '{i2cm_pkg::OP_TICK,  8'h00, 1'b1, 8'd1,  1'b1, BUS_ERR_BEAT},
    '{i2cm_pkg::OP_START, 8'h00, 1'b1, 8'd1,  1'b0, NO_BEAT},
    '{i2cm_pkg::OP_TICK,  8'h00, 1'b1, 8'd3,  1'b0, NO_BEAT},
    '{i2cm_pkg::OP_TICK,  8'h00, 1'b0, 8'd1,  1'b1, START_OK_BEAT},
    '{i2cm_pkg::OP_WRITE, 8'hFF, 1'b1, 8'd1,  1'b0, NO_BEAT},
    '{i2cm_pkg::OP_RDACK, 8'h00, 1'b1, 8'd1,  1'b0, NO_BEAT},
    '{i2cm_pkg::OP_TICK,  8'h00, 1'b1, 8'd24, 1'b0, NO_BEAT},
    '{i2cm_pkg::OP_TICK,  8'h00, 1'b1, 8'd1,  1'b1, WR_NACK_BEAT},
    '{i2cm_pkg::OP_WRITE, 8'h00, 1'b0, 8'd1,  1'b0, NO_BEAT},
    '{i2cm_pkg::OP_TICK,  8'h00, 1'b0, 8'd26, 1'b0, NO_BEAT},
    '{i2cm_pkg::OP_RDACK, 8'h00, 1'b1, 8'd1,  1'b0, NO_BEAT},
    '{i2cm_pkg::OP_TICK,  8'h00, 1'b1, 8'd18, 1'b0, NO_BEAT},
    '{i2cm_pkg::OP_TICK,  8'h00, 1'b1, 8'd1,  1'b1, RD_ACK_BEAT},
    '{i2cm_pkg::OP_RDNAK, 8'h00, 1'b0, 8'd1,  1'b0, NO_BEAT},
    '{i2cm_pkg::OP_TICK,  8'h00, 1'b0, 8'd18, 1'b0, NO_BEAT},
    '{i2cm_pkg::OP_TICK,  8'h00, 1'b0, 8'd1,  1'b1, RD_NACK_BEAT},
    '{i2cm_pkg::OP_STOP,  8'h00, 1'b1, 8'd1,  1'b0, NO_BEAT},
    '{i2cm_pkg::OP_RDNAK, 8'hFF, 1'b0, 8'd1,  1'b0, NO_BEAT},
    '{i2cm_pkg::OP_TICK,  8'h00, 1'b1, 8'd1,  1'b0, NO_BEAT},
    // start arriving on the done tick is still rejected
    '{i2cm_pkg::OP_START, 8'h00, 1'b1, 8'd1,  1'b1, STOP_REJ_BEAT},
    '{i2cm_pkg::OP_WRITE, 8'hA5, 1'b0, 8'd1,  1'b0, NO_BEAT}
  };

  i2c_master_bit_engine DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk = ~clk;

  function automatic void enter_phase(input logic [4:0] ph);
    eng_phase = ph;
    eng_wait = (cfg_ticks == 16'd0) ? 16'd1 : cfg_ticks;
    case (ph)
      i2cm_pkg::PH_ST_A:  eng_sda = 1'b1;
      i2cm_pkg::PH_ST_B:  eng_scl = 1'b1;
      i2cm_pkg::PH_ST_C:  eng_sda = 1'b0;
      i2cm_pkg::PH_ST_D:  eng_scl = 1'b0;
      i2cm_pkg::PH_SP_A:  eng_sda = 1'b0;
      i2cm_pkg::PH_SP_B:  eng_scl = 1'b1;
      i2cm_pkg::PH_SP_C:  eng_sda = 1'b1;
      i2cm_pkg::PH_WR_D: begin
        eng_scl = 1'b0;
        eng_sda = eng_shift[7];
        eng_shift = eng_shift << 1;
      end
      i2cm_pkg::PH_WR_H:  eng_scl = 1'b1;
      i2cm_pkg::PH_WR_L:  eng_scl = 1'b0;
      i2cm_pkg::PH_WR_AR: eng_sda = 1'b1;
      i2cm_pkg::PH_WR_AH: eng_scl = 1'b1;
      i2cm_pkg::PH_RD_H: begin
        eng_sda = 1'b1;
        eng_scl = 1'b1;
      end
      i2cm_pkg::PH_RD_L:  eng_scl = 1'b0;
      i2cm_pkg::PH_RD_K:  eng_sda = (eng_cmd == i2cm_pkg::OP_RDNAK);
      i2cm_pkg::PH_RD_KH: eng_scl = 1'b1;
      i2cm_pkg::PH_RD_KL: eng_scl = 1'b0;
      default: ;
    endcase
  endfunction

  function automatic logic close_cmd(input logic [1:0] st);
    eng_phase = i2cm_pkg::PH_IDLE;
    eng_wait = '0;
    eng_status = st;
    return 1'b1;
  endfunction

  // one tick of the engine: returns the result beat it produces
  function automatic i2cm_pkg::result_t predict_tick(input logic [2:0] op,
                                                     input logic [7:0] tx,
                                                     input logic sda);
    i2cm_pkg::result_t r;
    logic is_cmd;
    logic done;
    logic rej;
    is_cmd = (op >= i2cm_pkg::OP_START) && (op <= i2cm_pkg::OP_RDNAK);
    done = 1'b0;
    rej = 1'b0;
    if (eng_phase == i2cm_pkg::PH_IDLE) begin
      if (is_cmd) begin
        eng_cmd = op;
        eng_bit = '0;
        case (op)
          i2cm_pkg::OP_START: enter_phase(i2cm_pkg::PH_ST_A);
          i2cm_pkg::OP_STOP:  enter_phase(i2cm_pkg::PH_SP_A);
          i2cm_pkg::OP_WRITE: begin
            eng_shift = tx;
            enter_phase(i2cm_pkg::PH_WR_D);
          end
          default: begin
            eng_shift = '0;
            enter_phase(i2cm_pkg::PH_RD_H);
          end
        endcase
      end
    end else begin
      rej = is_cmd;
      if (eng_wait != 16'd0) eng_wait = eng_wait - 16'd1;
      if (eng_wait == 16'd0) begin
        case (eng_phase)
          i2cm_pkg::PH_ST_A: enter_phase(i2cm_pkg::PH_ST_B);
          i2cm_pkg::PH_ST_B: begin
            if (!sda) done = close_cmd(i2cm_pkg::ST_BUSY);
            else enter_phase(i2cm_pkg::PH_ST_C);
          end
          i2cm_pkg::PH_ST_C: enter_phase(i2cm_pkg::PH_ST_D);
          i2cm_pkg::PH_ST_D: done = close_cmd(sda ? i2cm_pkg::ST_ERR : i2cm_pkg::ST_OK);
          i2cm_pkg::PH_SP_A: enter_phase(i2cm_pkg::PH_SP_B);
          i2cm_pkg::PH_SP_B: enter_phase(i2cm_pkg::PH_SP_C);
          i2cm_pkg::PH_SP_C: done = close_cmd(i2cm_pkg::ST_OK);
          i2cm_pkg::PH_WR_D: enter_phase(i2cm_pkg::PH_WR_H);
          i2cm_pkg::PH_WR_H: enter_phase(i2cm_pkg::PH_WR_L);
          i2cm_pkg::PH_WR_L: begin
            if (eng_bit == 3'd7) enter_phase(i2cm_pkg::PH_WR_AR);
            else begin
              eng_bit = eng_bit + 3'd1;
              enter_phase(i2cm_pkg::PH_WR_D);
            end
          end
          i2cm_pkg::PH_WR_AR: enter_phase(i2cm_pkg::PH_WR_AH);
          i2cm_pkg::PH_WR_AH: begin
            eng_scl = 1'b0;
            done = close_cmd(sda ? i2cm_pkg::ST_NACK : i2cm_pkg::ST_OK);
          end
          i2cm_pkg::PH_RD_H: begin
            eng_shift = {eng_shift[6:0], sda};
            enter_phase(i2cm_pkg::PH_RD_L);
          end
          i2cm_pkg::PH_RD_L: begin
            if (eng_bit == 3'd7) begin
              eng_rx = eng_shift;
              enter_phase(i2cm_pkg::PH_RD_K);
            end else begin
              eng_bit = eng_bit + 3'd1;
              enter_phase(i2cm_pkg::PH_RD_H);
            end
          end
          i2cm_pkg::PH_RD_K:  enter_phase(i2cm_pkg::PH_RD_KH);
          i2cm_pkg::PH_RD_KH: enter_phase(i2cm_pkg::PH_RD_KL);
          default:            done = close_cmd(i2cm_pkg::ST_OK);
        endcase
      end
    end
    r.scl_drive = eng_scl;
    r.sda_drive = eng_sda;
    r.busy_res = (eng_phase != i2cm_pkg::PH_IDLE);
    r.done_res = done;
    r.status = eng_status;
    r.rx_byte = eng_rx;
    r.cmd_rejected = rej;
    return r;
  endfunction

  function automatic logic [2:0] pick_op(input bit engine_idle);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (engine_idle) begin
      if (roll < 65) return 3'($urandom_range(i2cm_pkg::OP_START, i2cm_pkg::OP_RDNAK));
      if (roll < 90) return i2cm_pkg::OP_TICK;
    end else begin
      if (roll < 88) return i2cm_pkg::OP_TICK;
      if (roll < 96) return 3'($urandom_range(i2cm_pkg::OP_START, i2cm_pkg::OP_RDNAK));
    end
    return $urandom_range(0, 1) ? OP_UNDEF6 : OP_UNDEF7;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    mismatches++;
    $display("%0t beat %0d %s: got %0h want %0h", $realtime, beats_seen, what, got, want);
  endtask

  task automatic check_beat(input logic [15:0] d);
    i2cm_pkg::result_t got;
    i2cm_pkg::result_t want;
    got = d[14:0];
    beats_seen++;
    if (expected_beats.size() == 0) begin
      report_mismatch("beat with nothing expected", 32'(d), 0);
      return;
    end
    want = expected_beats.pop_front();
    if (got.scl_drive !== want.scl_drive) report_mismatch("scl_drive", 32'(got.scl_drive),
                                                          32'(want.scl_drive));
    if (got.sda_drive !== want.sda_drive) report_mismatch("sda_drive", 32'(got.sda_drive),
                                                          32'(want.sda_drive));
    if (got.busy_res !== want.busy_res) report_mismatch("busy_res", 32'(got.busy_res),
                                                        32'(want.busy_res));
    if (got.done_res !== want.done_res) report_mismatch("done_res", 32'(got.done_res),
                                                        32'(want.done_res));
    if (got.status !== want.status) report_mismatch("status", 32'(got.status),
                                                    32'(want.status));
    if (got.rx_byte !== want.rx_byte) report_mismatch("rx_byte", 32'(got.rx_byte),
                                                      32'(want.rx_byte));
    if (got.cmd_rejected !== want.cmd_rejected) report_mismatch("cmd_rejected",
                                                                32'(got.cmd_rejected),
                                                                32'(want.cmd_rejected));
    if (d[15] !== 1'b0) report_mismatch("pad bit", 32'(d[15]), 0);
  endtask

  // offers one tick beat, waits for it to be taken, then books its result
  task automatic send_beat(input logic [2:0] op, input logic [7:0] tx, input logic sda,
                           input logic typed, input i2cm_pkg::result_t typed_beat);
    int unsigned gap;
    i2cm_pkg::result_t predicted;
    gap = idle_on ? $urandom_range(0, 19) : 0;
    @(negedge clk);
    if (gap != 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata = {4'b0000, sda, tx, op};
    do @(posedge clk); while (!s_axis_tready);
    predicted = predict_tick(op, tx, sda);
    expected_beats.push_back(typed ? typed_beat : predicted);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
  endtask

  // tick the current command to its end, then let the output side empty
  task automatic settle_engine();
    while (eng_phase != i2cm_pkg::PH_IDLE)
      send_beat(i2cm_pkg::OP_TICK, 8'($urandom), 1'($urandom), 1'b0, NO_BEAT);
    wait_drained();
    repeat (3) @(negedge clk);
  endtask

  task automatic write_phase_ticks(input logic [15:0] value);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we = 1'b0;
    cfg_ticks = value;
  endtask

  // result side
  initial begin
    int unsigned stall;
    wait (rst == 1'b0);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        m_axis_tready = 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        hold_req = 1'b0;
      end
      stall = idle_on ? $urandom_range(0, 19) : 0;
      if (stall != 0) begin
        m_axis_tready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_axis_tready = 1'b1;
      do @(posedge clk); while (!(m_axis_tvalid && m_axis_tready));
      check_beat(m_axis_tdata);
    end
  end

  // watchdog on cycles with no beat moving on either side
  initial begin
    int unsigned quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet = 0;
      else quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("watchdog: no beat moved for %0d cycles", STALL_LIMIT);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    int unsigned k;
    int unsigned n;
    logic [2:0] op;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (dir_rows[r])
      for (k = 0; k < dir_rows[r].reps; k++)
        send_beat(dir_rows[r].op, dir_rows[r].tx, dir_rows[r].sda, dir_rows[r].typed,
                  dir_rows[r].beat);

    foreach (tick_plan[p]) begin
      settle_engine();
      write_phase_ticks(16'(tick_plan[p]));
      idle_on = (p != 2);
      for (n = 0; n < ITEMS_PER_SETTING; n++) begin
        if (p == 3 && n == 40) hold_req = 1'b1;
        if (p == 1 && n == 130) wait_drained();
        op = pick_op(eng_phase == i2cm_pkg::PH_IDLE);
        send_beat(op, 8'($urandom), 1'($urandom), 1'b0, NO_BEAT);
      end
    end

    // longest hold per phase: start parks in its first phase, commands are rejected
    settle_engine();
    write_phase_ticks(16'hFFFF);
    idle_on = 1'b0;
    send_beat(i2cm_pkg::OP_START, 8'($urandom), 1'b0, 1'b0, NO_BEAT);
    for (n = 0; n < LONG_PHASE_BEATS; n++) begin
      op = ($urandom_range(0, 7) == 0) ? i2cm_pkg::OP_STOP : i2cm_pkg::OP_TICK;
      send_beat(op, 8'($urandom), 1'($urandom), 1'b0, NO_BEAT);
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatches == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule

[sim.f]
rtl/i2cm_pkg.sv
rtl/i2c_master_bit_engine.sv
dv/tb_i2c_master_bit_engine.sv
